// ===== rtl/ssc_pkg.sv =====
package ssc_pkg;

    // Display geometry.
    localparam int unsigned COLUMNS    = 256;
    localparam int unsigned SCOPE_ROWS = 80;
    localparam logic [8:0]  CENTRE_BIN = 9'(COLUMNS / 2);

    // Configuration register indexes.
    localparam logic [2:0] CFG_ZOOM       = 3'd0;
    localparam logic [2:0] CFG_PASS_START = 3'd1;
    localparam logic [2:0] CFG_PASS_STOP  = 3'd2;
    localparam logic [2:0] CFG_USB_ON     = 3'd3;
    localparam logic [2:0] CFG_LSB_ON     = 3'd4;
    localparam logic [2:0] CFG_TEN_DB     = 3'd5;
    localparam logic [2:0] CFG_GREY       = 3'd6;

    localparam logic [4:0]  ZOOM_RESET = 5'd1;
    localparam logic [15:0] GREY_RESET = 16'd33808;
    localparam logic [15:0] WHITE_565  = 16'hffff;

    // Reciprocals for the constant divisions.
    // x*80/270 for an 8-bit x: (x * BAR_RECIP) >> 16, exact over the byte range.
    localparam logic [14:0] BAR_RECIP = 15'd19419;
    // x/5 for x below 2048: (x * DIV5_RECIP) >> 16.
    localparam logic [13:0] DIV5_RECIP = 14'd13108;
    // x/15 for x below 20000: (x * DIV15_RECIP) >> 20.
    localparam logic [16:0] DIV15_RECIP = 17'd69906;

    // Green blend colour, quarter and three quarters of full scale.
    localparam logic [7:0] BLEND_G_ADD = 8'd63;
    localparam logic [7:0] HL_G_ADD    = 8'd192;

    // Where the final pixel colour comes from.
    typedef enum logic [1:0] {
        SRC_HEAT,
        SRC_WHITE,
        SRC_GREY
    } t_src;

    // First stage: decoded position, bar height and tick spacings.
    typedef struct packed {
        logic       mode;
        logic [8:0] fbin;
        logic [7:0] afb;
        logic [6:0] row;
        logic [7:0] level;
        logic [6:0] bar;
        logic [6:0] rdiv;
        logic [8:0] ts;
    } t_s1;

    // Second stage: pixel class flags and the partial row remainder.
    typedef struct packed {
        logic       mode;
        logic [7:0] level;
        logic [3:0] row_lo;
        logic [6:0] rem;
        logic [6:0] rdiv;
        logic [7:0] rowval;
        logic       below;
        logic       on_bar;
        logic       cursor;
        logic       pass;
        logic       col_tick;
    } t_s2;

    // Third stage: heatmap segment and fraction, blend controls, source.
    typedef struct packed {
        logic [2:0] seg;
        logic [7:0] f;
        logic       blend;
        logic       hl;
        t_src       src;
    } t_s3;

    // One restoring division step: shift in a dividend bit, subtract if it fits.
    function automatic logic [6:0] div_step(input logic [6:0] rem, input logic bit_in,
                                            input logic [6:0] d);
        logic [7:0] t;
        begin
            t = {rem, bit_in};
            if (t >= {1'b0, d}) begin
                t = t - {1'b0, d};
            end
            return t[6:0];
        end
    endfunction

    // Six-segment heatmap, optional green blend and highlight, packed as RGB565.
    function automatic logic [15:0] heat565(input logic [2:0] seg, input logic [7:0] f,
                                            input logic blend, input logic hl);
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        begin
            case (seg)
                3'd0: begin
                    r = 8'd0;   g = 8'd0;        b = f;
                end
                3'd1: begin
                    r = 8'd0;   g = f;           b = 8'd255;
                end
                3'd2: begin
                    r = 8'd0;   g = 8'd255;      b = 8'd255 - f;
                end
                3'd3: begin
                    r = f;      g = 8'd255;      b = 8'd0;
                end
                3'd4: begin
                    r = 8'd255; g = 8'd255 - f;  b = 8'd0;
                end
                default: begin
                    r = 8'd255; g = f;           b = f;
                end
            endcase
            if (blend) begin
                r = r - (r >> 2);
                g = g - (g >> 2) + BLEND_G_ADD;
                b = b - (b >> 2);
            end
            if (hl) begin
                r = r >> 2;
                g = (g >> 2) + HL_G_ADD;
                b = b >> 2;
            end
            return {r[7:3], g[7:2], b[7:3]};
        end
    endfunction

endpackage

// ===== rtl/spectrum_scope_pixel_colouriser.sv =====
// Colours one spectrum-scope or waterfall pixel per beat and returns it as RGB565.
// The block is a four-stage pipeline with no memories: it accepts one pixel every
// clock while o_in_stall is low, and each colour passes through the four register
// stages (bar height and tick spacing, pixel classification and the first three
// steps of the row-tick division, its last four steps and the heatmap segment,
// then the colour output register). Stages holding a bubble fill even while the
// output is stalled, so the input stalls only when all four stages hold a pixel.
// The user must write configuration through the plain write port only while no
// pixel is in flight; the block itself does not enforce this.
module spectrum_scope_pixel_colouriser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Pixel request channel.
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_mode,
    input  logic [7:0]  i_column,
    input  logic [6:0]  i_row,
    input  logic [7:0]  i_level,
    // Pixel colour channel.
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_colour,
    // Configuration write port.
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import ssc_pkg::*;

    // Configuration registers.
    logic [4:0]  r_zoom;
    logic [6:0]  r_pass_start;
    logic [6:0]  r_pass_stop;
    logic        r_usb_on;
    logic        r_lsb_on;
    logic [7:0]  r_ten_db_step;
    logic [15:0] r_grey;

    // Pipeline registers.
    logic        r_s1_v;
    logic        r_s2_v;
    logic        r_s3_v;
    logic        r_out_v;
    t_s1         r_s1;
    t_s2         r_s2;
    t_s3         r_s3;
    logic [15:0] r_colour;
    t_s1         n_s1;
    t_s2         n_s2;
    t_s3         n_s3;
    logic [15:0] n_colour;

    // Stage enables.
    logic w_en1;
    logic w_en2;
    logic w_en3;
    logic w_en4;

    // Stage one intermediates.
    logic [8:0]  w_neg_fbin;
    logic [22:0] w_bar_prod;
    logic [22:0] w_rdiv_prod;
    logic [14:0] w_ts_x;
    logic [31:0] w_ts_prod;

    // Stage two intermediates.
    logic [11:0] w_lo;
    logic [11:0] w_hi;
    logic [12:0] w_fb13;
    logic [12:0] w_nfb13;
    logic        w_usb;
    logic        w_lsb;
    logic [10:0] w_m1;
    logic [10:0] w_m2;
    logic [10:0] w_m3;
    logic [10:0] w_m4;
    logic [10:0] w_m5;
    logic [10:0] w_afb11;
    logic [24:0] w_rowval_prod;
    logic [6:0]  w_rem_a;
    logic [6:0]  w_rem_b;

    // Stage three intermediates.
    logic [6:0]  w_rem_c;
    logic [6:0]  w_rem_d;
    logic [6:0]  w_rem_e;
    logic [6:0]  w_rem_f;
    logic        w_row_tick;
    logic [7:0]  w_val;
    logic [10:0] w_v6;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zoom        <= ZOOM_RESET;
            r_pass_start  <= '0;
            r_pass_stop   <= '0;
            r_usb_on      <= 1'b0;
            r_lsb_on      <= 1'b0;
            r_ten_db_step <= '0;
            r_grey        <= GREY_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ZOOM:       r_zoom        <= i_cfg_data[4:0];
                CFG_PASS_START: r_pass_start  <= i_cfg_data[6:0];
                CFG_PASS_STOP:  r_pass_stop   <= i_cfg_data[6:0];
                CFG_USB_ON:     r_usb_on      <= i_cfg_data[0];
                CFG_LSB_ON:     r_lsb_on      <= i_cfg_data[0];
                CFG_TEN_DB:     r_ten_db_step <= i_cfg_data[7:0];
                CFG_GREY:       r_grey        <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // A stage loads when it is empty or when the stage after it moves on.
    assign w_en4      = !r_out_v || !i_out_stall;
    assign w_en3      = !r_s3_v || w_en4;
    assign w_en2      = !r_s2_v || w_en3;
    assign w_en1      = !r_s1_v || w_en2;
    assign o_in_stall = !w_en1;

    // Stage one: bin offset, bar height and the two tick spacings.
    always_comb begin
        n_s1.mode  = i_mode;
        n_s1.row   = i_row;
        n_s1.level = i_level;
        n_s1.fbin  = {1'b0, i_column} - CENTRE_BIN;
        w_neg_fbin = 9'd0 - n_s1.fbin;
        n_s1.afb   = n_s1.fbin[8] ? w_neg_fbin[7:0] : n_s1.fbin[7:0];

        w_bar_prod  = {15'd0, i_level} * {8'd0, BAR_RECIP};
        w_rdiv_prod = {15'd0, r_ten_db_step} * {8'd0, BAR_RECIP};
        n_s1.bar    = w_bar_prod[22:16];
        n_s1.rdiv   = w_rdiv_prod[22:16];

        // Column tick spacing is 256*zoom/30 bins, five times that below zoom 3.
        if (r_zoom >= 5'd3) begin
            w_ts_x = {3'd0, r_zoom, 7'd0};
        end else begin
            w_ts_x = {1'b0, r_zoom, 9'd0} + {3'd0, r_zoom, 7'd0};
        end
        w_ts_prod = {17'd0, w_ts_x} * {15'd0, DIV15_RECIP};
        n_s1.ts   = w_ts_prod[28:20];
    end

    // Stage two: passband, cursor, bar position, column ticks, heat row value, first division steps.
    always_comb begin
        n_s2.mode   = r_s1.mode;
        n_s2.level  = r_s1.level;
        n_s2.row_lo = r_s1.row[3:0];
        n_s2.rdiv   = r_s1.rdiv;

        w_lo    = 12'(r_pass_start) * 12'(r_zoom);
        w_hi    = 12'(r_pass_stop) * 12'(r_zoom);
        w_fb13  = {{4{r_s1.fbin[8]}}, r_s1.fbin};
        w_nfb13 = 13'd0 - w_fb13;
        w_usb   = ($signed(w_fb13) > $signed({1'b0, w_lo}))
               && ($signed(w_fb13) < $signed({1'b0, w_hi})) && r_usb_on;
        w_lsb   = ($signed(w_nfb13) > $signed({1'b0, w_lo}))
               && ($signed(w_nfb13) < $signed({1'b0, w_hi})) && r_lsb_on;
        n_s2.pass   = w_usb || w_lsb;
        n_s2.cursor = (r_s1.fbin == 9'd0);

        n_s2.below  = (r_s1.row < r_s1.bar);
        n_s2.on_bar = (r_s1.row == r_s1.bar);

        // A non-zero spacing is at least 25 bins, so five multiples cover the span.
        w_m1    = {2'd0, r_s1.ts};
        w_m2    = {1'b0, r_s1.ts, 1'b0};
        w_m3    = w_m1 + w_m2;
        w_m4    = {r_s1.ts, 2'b0};
        w_m5    = w_m4 + w_m1;
        w_afb11 = {3'd0, r_s1.afb};
        n_s2.col_tick = (r_s1.ts != 9'd0) && (r_s1.afb != 8'd0)
                     && ((w_afb11 == w_m1) || (w_afb11 == w_m2) || (w_afb11 == w_m3)
                      || (w_afb11 == w_m4) || (w_afb11 == w_m5));

        // Heat index of the row: row*256/80 taken modulo 256.
        w_rowval_prod = {14'd0, r_s1.row, 4'd0} * {11'd0, DIV5_RECIP};
        n_s2.rowval   = w_rowval_prod[23:16];

        // Row remainder by the row tick spacing: the top three dividend bits.
        w_rem_a  = div_step(7'd0, r_s1.row[6], r_s1.rdiv);
        w_rem_b  = div_step(w_rem_a, r_s1.row[5], r_s1.rdiv);
        n_s2.rem = div_step(w_rem_b, r_s1.row[4], r_s1.rdiv);
    end

    // Stage three: finish the division, choose the heat value and colour source.
    always_comb begin
        w_rem_c    = div_step(r_s2.rem, r_s2.row_lo[3], r_s2.rdiv);
        w_rem_d    = div_step(w_rem_c, r_s2.row_lo[2], r_s2.rdiv);
        w_rem_e    = div_step(w_rem_d, r_s2.row_lo[1], r_s2.rdiv);
        w_rem_f    = div_step(w_rem_e, r_s2.row_lo[0], r_s2.rdiv);
        w_row_tick = (r_s2.rdiv != 7'd0) && (w_rem_f == 7'd0);

        if (r_s2.mode) begin
            w_val = r_s2.level;
        end else if (r_s2.below) begin
            w_val = r_s2.rowval;
        end else begin
            w_val = 8'd0;
        end
        w_v6     = {1'b0, w_val, 2'b0} + {2'b0, w_val, 1'b0};
        n_s3.seg = w_v6[10:8];
        n_s3.f   = w_v6[7:0];

        // The cursor below the bar is blended as well as highlighted.
        n_s3.blend = r_s2.pass || (!r_s2.mode && r_s2.below && r_s2.cursor);
        n_s3.hl    = r_s2.cursor;

        if (!r_s2.mode && r_s2.on_bar) begin
            n_s3.src = SRC_WHITE;
        end else if (!r_s2.mode && !r_s2.below && (r_s2.col_tick || w_row_tick)) begin
            n_s3.src = SRC_GREY;
        end else begin
            n_s3.src = SRC_HEAT;
        end
    end

    // Stage four: final colour.
    always_comb begin
        case (r_s3.src)
            SRC_WHITE: n_colour = WHITE_565;
            SRC_GREY:  n_colour = r_grey;
            default:   n_colour = heat565(r_s3.seg, r_s3.f, r_s3.blend, r_s3.hl);
        endcase
    end

    // Valid bits travel with the pixels.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_s3_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (w_en1) begin
                r_s1_v <= i_in_valid;
            end
            if (w_en2) begin
                r_s2_v <= r_s1_v;
            end
            if (w_en3) begin
                r_s3_v <= r_s2_v;
            end
            if (w_en4) begin
                r_out_v <= r_s3_v;
            end
        end
    end

    // Pixel payload registers.
    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_s1 <= n_s1;
        end
        if (w_en2) begin
            r_s2 <= n_s2;
        end
        if (w_en3) begin
            r_s3 <= n_s3;
        end
        if (w_en4) begin
            r_colour <= n_colour;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_colour    = r_colour;

    // The input stalls only when every stage holds a pixel.
    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_s1_v && r_s2_v && r_s3_v && r_out_v))
        else $error("input stalled while a pipeline stage was empty");

    // The centre column can never fall inside the passband.
    a_cursor_not_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_v && r_s2.cursor) |-> !r_s2.pass)
        else $error("centre column marked as passband");

    // The partial row remainder stays below a non-zero divisor.
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_v && (r_s2.rdiv != 7'd0)) |-> (r_s2.rem < r_s2.rdiv))
        else $error("row remainder out of range");

    // A beat that moves on from stage three is the one shown at the output.
    a_out_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s3_v && w_en4) |=> r_out_v)
        else $error("pixel lost between stage three and the output");

endmodule
